// ===== design/pfc_pkg.sv =====
// shared types, constants and helper functions of the playfair digraph cipher
package pfc_pkg;

   // letter code, A=0 through Z=25
   typedef logic [4:0] letter_type;
   // row or column of the key square, 0..4
   typedef logic [2:0] coord_type;
   // whole key square, entry p at bits 5p..5p+4
   typedef logic [124:0] square_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } spot_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_ROWS_0_1 = 2'd0,
      CSR_ROWS_2_3 = 2'd1,
      CSR_ROW_4    = 2'd2
   } csr_index_type;

   localparam int unsigned SIDE = 5;
   localparam int unsigned WIDE_REG_W = 50;
   localparam int unsigned ROW4_REG_W = 25;

   localparam letter_type LETTER_X = 5'd23;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_I = 5'd8;

   // step one place forward or back around the square, modulo five
   function automatic coord_type step_coord(input coord_type v, input logic back);
      logic [3:0] sum;
      begin
         sum = {1'b0, v} + (back ? 4'd4 : 4'd1);
         if (sum >= 4'(SIDE)) begin
            sum = sum - 4'(SIDE);
         end
         step_coord = sum[2:0];
      end
   endfunction

   // entry at a given row and column
   function automatic letter_type cell_at(input square_type sq, input coord_type row,
                                          input coord_type col);
      logic [4:0] pos;
      logic [6:0] base;
      begin
         pos = {row[2:0], 2'b00} + {2'b00, row} + {2'b00, col};
         base = {pos, 2'b00} + {2'b00, pos};
         cell_at = sq[base +: 5];
      end
   endfunction

   // lowest position holding the letter, row 0 column 0 when absent
   function automatic spot_type locate(input square_type sq, input letter_type letter);
      spot_type spot;
      begin
         spot = '0;
         for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
               if (sq[(r * SIDE + c) * 5 +: 5] == letter) begin
                  spot.row = 3'(r);
                  spot.col = 3'(c);
               end
            end
         end
         locate = spot;
      end
   endfunction

endpackage

// ===== design/playfair_digraph_cipher_top.sv =====
// top level of the playfair digraph cipher: key square registers and substitution path
//
// One letter pair is taken per clock cycle, every cycle: busy never rises. An accepted
// item is loaded into the input register, then makes one pass through the square
// lookup (letter compares, rule select, entry select) into the result register, which
// shows it on the rsp_ ports, marked by rsp_strobe, for a single cycle. The receiver
// cannot stall, so results leave in acceptance order. The user must write the key
// square through the csr_ port only while no item is in flight; the block itself does
// not enforce this.
module playfair_digraph_cipher_top
   import pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // item channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_type,
   input  logic [4:0]            req_first_letter,
   input  logic [4:0]            req_second_letter,
   input  logic                  req_second_present,
   // result channel
   output logic                  rsp_strobe,
   output logic [4:0]            rsp_out_first,
   output logic [4:0]            rsp_out_second,
   output logic                  rsp_first_was_j,
   output logic                  rsp_second_was_j,
   output logic                  rsp_second_was_x,
   output logic                  rsp_second_padded,
   // configuration port
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [WIDE_REG_W-1:0] csr_wdata
);

   logic [WIDE_REG_W-1:0] sq01_ff;
   logic [WIDE_REG_W-1:0] sq23_ff;
   logic [ROW4_REG_W-1:0] sq4_ff;
   square_type            square;

   logic       in_valid_ff;
   logic       dec_ff;
   letter_type first_ff;
   letter_type second_ff;
   logic       present_ff;

   logic       enc;
   logic       sx_in, sp_in, fj_in, sj_in;
   letter_type a_pad, b_pad, a_map, b_map;
   spot_type   spot_a, spot_b;
   coord_type  ra_out, ca_out, rb_out, cb_out;
   letter_type oa_in, ob_in;

   logic       rsp_strobe_ff;
   letter_type oa_ff, ob_ff;
   logic       fj_ff, sj_ff, sx_ff, sp_ff;

   // no multi-cycle work, so a new item is always welcome
   assign busy = 1'b0;

   // key square registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sq01_ff <= '0;
         sq23_ff <= '0;
         sq4_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS_0_1: sq01_ff <= csr_wdata;
            CSR_ROWS_2_3: sq23_ff <= csr_wdata;
            CSR_ROW_4:    sq4_ff  <= csr_wdata[ROW4_REG_W-1:0];
            default:      ;
         endcase
      end
   end

   assign square = {sq4_ff, sq23_ff, sq01_ff};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         dec_ff     <= req_type;
         first_ff   <= req_first_letter;
         second_ff  <= req_second_letter;
         present_ff <= req_second_present;
      end
   end

   // padding and j mapping, encrypt only
   always_comb begin
      enc   = !dec_ff;
      sx_in = enc && present_ff && (second_ff == LETTER_X);
      sp_in = enc && (!present_ff || (second_ff == first_ff));
      a_pad = first_ff;
      b_pad = sp_in ? LETTER_X : second_ff;
      fj_in = enc && (a_pad == LETTER_J);
      sj_in = enc && (b_pad == LETTER_J);
      a_map = fj_in ? LETTER_I : a_pad;
      b_map = sj_in ? LETTER_I : b_pad;
   end

   // find both letters and apply the column, row or rectangle rule
   always_comb begin
      spot_a = locate(square, a_map);
      spot_b = locate(square, b_map);
      if (spot_a.col == spot_b.col) begin
         ra_out = step_coord(spot_a.row, dec_ff);
         rb_out = step_coord(spot_b.row, dec_ff);
         ca_out = spot_a.col;
         cb_out = spot_b.col;
      end else if (spot_a.row == spot_b.row) begin
         ra_out = spot_a.row;
         rb_out = spot_b.row;
         ca_out = step_coord(spot_a.col, dec_ff);
         cb_out = step_coord(spot_b.col, dec_ff);
      end else begin
         ra_out = spot_a.row;
         rb_out = spot_b.row;
         ca_out = spot_b.col;
         cb_out = spot_a.col;
      end
      oa_in = cell_at(square, ra_out, ca_out);
      ob_in = cell_at(square, rb_out, cb_out);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         oa_ff <= oa_in;
         ob_ff <= ob_in;
         fj_ff <= fj_in;
         sj_ff <= sj_in;
         sx_ff <= sx_in;
         sp_ff <= sp_in;
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_out_first     = oa_ff;
   assign rsp_out_second    = ob_ff;
   assign rsp_first_was_j   = fj_ff;
   assign rsp_second_was_j  = sj_ff;
   assign rsp_second_was_x  = sx_ff;
   assign rsp_second_padded = sp_ff;

endmodule

// ===== design/pfc_checker.sv =====
// port-level checks of the playfair digraph cipher and their binding
module pfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_type,
   input logic       req_second_present,
   input logic       rsp_strobe,
   input logic       rsp_first_was_j,
   input logic       rsp_second_was_j,
   input logic       rsp_second_was_x,
   input logic       rsp_second_padded
);

   // every accepted item gives its result, through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("accepted item produced no result");

   // no result without an accepted item behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result without accepted item");

   // decrypt results carry no flags
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_type, 2)) |->
      !(rsp_first_was_j || rsp_second_was_j || rsp_second_was_x || rsp_second_padded))
      else $error("flag set on decrypt item");

   // a lone first letter on encrypt is always padded
   assert property (@(posedge clock) disable iff (reset)
      $past(start && !busy && !req_type && !req_second_present, 2) |->
      (rsp_strobe && rsp_second_padded && !rsp_second_was_x))
      else $error("missing second letter not padded");

endmodule

bind playfair_digraph_cipher_top pfc_checker u_pfc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_type           (req_type),
   .req_second_present (req_second_present),
   .rsp_strobe         (rsp_strobe),
   .rsp_first_was_j    (rsp_first_was_j),
   .rsp_second_was_j   (rsp_second_was_j),
   .rsp_second_was_x   (rsp_second_was_x),
   .rsp_second_padded  (rsp_second_padded)
);
